FILE: hw/rtl/gccc_pkg.sv
// types and constants for the grapheme cluster column clipper
// no dependencies; imported by grapheme_cluster_column_clipper
package gccc_pkg;

   localparam int unsigned CP_W  = 21;
   localparam int unsigned COL_W = 16;

   typedef logic [CP_W-1:0]  cp_type;
   typedef logic [COL_W-1:0] col_type;

   typedef enum logic [1:0] {
      STATUS_ACCEPTED  = 2'd0,
      STATUS_RUN_FULL  = 2'd1,
      STATUS_ZERO_RUN  = 2'd2,
      STATUS_IGNORED   = 2'd3
   } status_type;

   localparam col_type MAX_COLS_RESET = 16'd80;

   localparam cp_type RI_LO     = 21'h1F1E6;
   localparam cp_type RI_HI     = 21'h1F1FF;
   localparam cp_type SKIN_LO   = 21'h1F3FB;
   localparam cp_type SKIN_HI   = 21'h1F3FF;
   localparam cp_type VS_LO     = 21'h0FE00;
   localparam cp_type VS_HI     = 21'h0FE0F;
   localparam cp_type VS_SUP_LO = 21'hE0100;
   localparam cp_type VS_SUP_HI = 21'hE01EF;
   localparam cp_type EMOJI_LO  = 21'h1F000;
   localparam cp_type EMOJI_HI  = 21'h1FAFF;
   localparam cp_type MISC_LO   = 21'h02600;
   localparam cp_type MISC_HI   = 21'h026FF;
   localparam cp_type CHECK_MARK = 21'h02705;
   localparam cp_type ZWJ       = 21'h0200D;
   localparam cp_type ZWNJ      = 21'h0200C;

   typedef struct packed {
      logic has_base;
      logic emoji_cluster;
      logic indicator_waiting;
      logic joiner_waiting;
   } flags_type;

endpackage

FILE: hw/rtl/grapheme_cluster_column_clipper.sv
// grapheme cluster column clipper: cluster rule, column count and run clipping
// depends on gccc_pkg
//
// Takes one code point per cycle while req_stall is low and returns one result
// per item by way of the input register, then the result register. Back-to-back
// items flow at one per cycle unless rsp_stall holds them; the limit is the
// per-item state loop in the compute stage (cluster flags plus one 17-bit add
// and compare against the limit). Each result says whether the character joins
// the previous cluster, the run status and the columns held. Once a run ends,
// items are ignored until one arrives with run_start set. The limit register may
// be written at any time the block is idle; csr_ready is always high.
module grapheme_cluster_column_clipper
   import gccc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  cp_type     req_code_point,
   input  logic [1:0] req_char_width,
   input  logic       req_last_of_text,
   input  logic       req_run_start,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_continues_cluster,
   output logic [1:0] rsp_status,
   output col_type    rsp_run_columns,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  col_type    csr_data
);

   col_type    max_cols_ff;

   logic       in_valid_ff;
   cp_type     in_cp_ff;
   logic [1:0] in_width_ff;
   logic       in_last_ff;
   logic       in_start_ff;

   flags_type  flags_ff, flags_in;
   col_type    used_ff, used_in;
   col_type    cluster_ff, cluster_in;
   logic       ended_ff, ended_in;

   logic       out_valid_ff;
   logic       out_cont_ff, out_cont_in;
   status_type out_status_ff, out_status_in;
   col_type    out_cols_ff;

   logic       out_free;
   logic       advance;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   // compute stage
   always_comb begin
      flags_type   f;
      col_type     used_cur;
      col_type     clus_cur;
      logic        ended_cur;
      logic        joins;
      logic        is_ri, is_skin, is_vs, is_emoji;
      logic [16:0] total;
      logic [16:0] clus_sum;

      f         = in_start_ff ? '0 : flags_ff;
      used_cur  = in_start_ff ? '0 : used_ff;
      clus_cur  = in_start_ff ? '0 : cluster_ff;
      ended_cur = in_start_ff ? 1'b0 : ended_ff;

      is_ri    = (in_cp_ff >= RI_LO) && (in_cp_ff <= RI_HI);
      is_skin  = (in_cp_ff >= SKIN_LO) && (in_cp_ff <= SKIN_HI);
      is_vs    = ((in_cp_ff >= VS_LO) && (in_cp_ff <= VS_HI))
              || ((in_cp_ff >= VS_SUP_LO) && (in_cp_ff <= VS_SUP_HI))
              || ((in_width_ff == 2'd0) && (in_cp_ff != ZWNJ) && (in_cp_ff != ZWJ));
      is_emoji = ((in_cp_ff >= EMOJI_LO) && (in_cp_ff <= EMOJI_HI))
              || ((in_cp_ff >= MISC_LO) && (in_cp_ff <= MISC_HI))
              || (in_cp_ff == CHECK_MARK);

      joins = 1'b0;
      if (f.joiner_waiting) begin
         f.joiner_waiting    = 1'b0;
         f.indicator_waiting = 1'b0;
         f.has_base          = 1'b1;
         f.emoji_cluster     = 1'b1;
         joins               = 1'b1;
      end else if (is_ri) begin
         joins               = f.indicator_waiting;
         f.indicator_waiting = !f.indicator_waiting;
         f.has_base          = 1'b1;
         f.emoji_cluster     = 1'b0;
      end else begin
         f.indicator_waiting = 1'b0;
         if (is_skin && f.has_base && f.emoji_cluster) begin
            joins = 1'b1;
         end else if (is_vs) begin
            if (f.has_base) begin
               joins = 1'b1;
            end else begin
               f.emoji_cluster = 1'b0;
            end
         end else if ((in_cp_ff == ZWJ) && f.has_base && f.emoji_cluster && !in_last_ff) begin
            f.joiner_waiting = 1'b1;
            joins            = 1'b1;
         end else begin
            f.has_base      = 1'b1;
            f.emoji_cluster = is_emoji;
         end
      end

      total    = {1'b0, used_cur} + {15'd0, in_width_ff};
      clus_sum = {1'b0, clus_cur} + {15'd0, in_width_ff};

      flags_in      = f;
      used_in       = used_cur;
      cluster_in    = clus_cur;
      ended_in      = ended_cur;
      out_cont_in   = joins;
      out_status_in = STATUS_ACCEPTED;

      if (ended_cur) begin
         // run already over: state holds, apart from the start clear
         flags_in      = in_start_ff ? '0 : flags_ff;
         out_cont_in   = 1'b0;
         out_status_in = STATUS_IGNORED;
      end else if (total > {1'b0, max_cols_ff}) begin
         // back out the partial cluster this character would have joined
         if (joins) begin
            used_in = (clus_cur <= used_cur) ? used_cur - clus_cur : '0;
         end
         cluster_in    = '0;
         ended_in      = 1'b1;
         out_status_in = (used_in == '0) ? STATUS_ZERO_RUN : STATUS_RUN_FULL;
      end else begin
         used_in = total[COL_W-1:0];
         if (joins) begin
            cluster_in = clus_sum[COL_W] ? '1 : clus_sum[COL_W-1:0];
         end else begin
            cluster_in = {14'd0, in_width_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_cols_ff   <= MAX_COLS_RESET;
         in_valid_ff   <= 1'b0;
         flags_ff      <= '0;
         used_ff       <= '0;
         cluster_ff    <= '0;
         ended_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_cols_ff <= csr_data;
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            flags_ff   <= flags_in;
            used_ff    <= used_in;
            cluster_ff <= cluster_in;
            ended_ff   <= ended_in;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_cp_ff    <= req_code_point;
         in_width_ff <= req_char_width;
         in_last_ff  <= req_last_of_text;
         in_start_ff <= req_run_start;
      end
      if (advance) begin
         out_cont_ff   <= out_cont_in;
         out_status_ff <= out_status_in;
         out_cols_ff   <= used_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_continues_cluster = out_cont_ff;
   assign rsp_status            = out_status_ff;
   assign rsp_run_columns       = out_cols_ff;

   a_cluster_within_run: assert property (@(posedge clock) disable iff (reset)
      cluster_ff <= used_ff)
      else $error("cluster columns exceed run columns");

   a_joiner_has_emoji_base: assert property (@(posedge clock) disable iff (reset)
      flags_ff.joiner_waiting |-> (flags_ff.has_base && flags_ff.emoji_cluster))
      else $error("joiner waiting without an emoji base");

   a_zero_run_empty: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_status_ff == STATUS_ZERO_RUN)) |-> (out_cols_ff == '0))
      else $error("zero-width run error with columns held");

   a_full_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_status_ff == STATUS_RUN_FULL)) |-> (out_cols_ff != '0))
      else $error("run full reported with no columns");

   a_ignored_no_join: assert property (@(posedge clock) disable iff (reset)
      (advance && (out_status_in == STATUS_IGNORED)) |=> (ended_ff && !out_cont_ff))
      else $error("ignored item joined a cluster or run not ended");

endmodule
